@@ hw/rtl/bfdp_pkg.sv @@
package bfdp_pkg;

    localparam int SampleWidth  = 16;
    localparam int IndexWidth   = 8;
    localparam int BitWidth     = 3;
    localparam int PayloadWidth = 9;
    localparam int LimitWidth   = 8;

    localparam logic [1:0] STATUS_BASE   = 2'd0;
    localparam logic [1:0] STATUS_SHORT  = 2'd1;
    localparam logic [1:0] STATUS_LONG   = 2'd2;
    localparam logic [1:0] STATUS_REJECT = 2'd3;

    localparam logic [LimitWidth-1:0]  LIMIT_RESET   = 8'd64;
    localparam logic [BitWidth-1:0]    BIT_FIRST     = 3'd7;
    localparam logic [BitWidth-1:0]    BIT_LAST      = 3'd0;
    localparam logic [SampleWidth-1:0] SHORT_NEG_MIN = 16'hFF80;
    localparam logic [SampleWidth-1:0] SHORT_POS_MAX = 16'd126;
    localparam logic [PayloadWidth:0]  NEAR_MARGIN   = 10'd3;

    typedef struct packed {
        logic [SampleWidth-1:0] sample;
        logic                   new_packet;
    } in_t;

    typedef struct packed {
        logic [1:0]              status;
        logic [SampleWidth-1:0]  code;
        logic [IndexWidth-1:0]   bitmap_index;
        logic [BitWidth-1:0]     bitmap_bit;
        logic [PayloadWidth-1:0] payload_bytes;
        logic                    near_full;
    } out_t;

endpackage

@@ hw/rtl/bitmap_flagged_delta_packer.sv @@
// Delta packer with a short/long flag bitmap. Each input transaction is one 16-bit sample;
// each produces exactly one result transaction, in order. The first sample after new_packet
// (or reset) becomes the base; later samples are coded as their wrapped difference from it,
// one byte for differences in -128..126 and two bytes otherwise, with a bitmap byte added
// at the start of every group of eight codes. A sample that would exceed max_payload_bytes
// is rejected, and so is every later sample until new_packet. One sample per clock is
// sustained while out_stall is low: a sample is captured in the input register, where the
// subtract, range compare and limit compare run against the packet counters, and then moves
// to the result register. max_payload_bytes is written through cfg_valid / cfg_ready
// (always ready) and must only change while no transaction is in flight.
module bitmap_flagged_delta_packer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  bfdp_pkg::in_t        in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output bfdp_pkg::out_t       out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [7:0]           cfg_data
);
    import bfdp_pkg::*;

    logic                    s1_valid_reg;
    in_t                     s1_data_reg;
    logic                    out_valid_reg;
    out_t                    out_data_reg;
    out_t                    out_data_next;
    logic [LimitWidth-1:0]   limit_reg;

    logic                    base_valid_reg,  base_valid_next;
    logic [SampleWidth-1:0]  base_value_reg,  base_value_next;
    logic [PayloadWidth-1:0] payload_reg,     payload_next;
    logic [BitWidth-1:0]     bit_pos_reg,     bit_pos_next;
    logic [IndexWidth-1:0]   byte_idx_reg,    byte_idx_next;
    logic                    full_reg,        full_next;

    logic                    out_open;
    logic                    s1_fire;
    logic                    in_fire;

    logic                    cur_base_valid;
    logic [SampleWidth-1:0]  cur_base_value;
    logic [PayloadWidth-1:0] cur_payload;
    logic [BitWidth-1:0]     cur_bit_pos;
    logic [IndexWidth-1:0]   cur_byte_idx;
    logic                    cur_full;
    logic [SampleWidth-1:0]  diff;
    logic                    is_short;
    logic [PayloadWidth:0]   need;

    assign out_open  = !out_valid_reg || !out_stall;
    assign s1_fire   = s1_valid_reg && out_open;
    assign in_stall  = s1_valid_reg && !out_open;
    assign in_fire   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        if (s1_data_reg.new_packet)
        begin
            cur_base_valid = 1'b0;
            cur_base_value = '0;
            cur_payload    = '0;
            cur_bit_pos    = BIT_FIRST;
            cur_byte_idx   = '0;
            cur_full       = 1'b0;
        end
        else
        begin
            cur_base_valid = base_valid_reg;
            cur_base_value = base_value_reg;
            cur_payload    = payload_reg;
            cur_bit_pos    = bit_pos_reg;
            cur_byte_idx   = byte_idx_reg;
            cur_full       = full_reg;
        end

        diff     = s1_data_reg.sample - cur_base_value;
        is_short = (diff >= SHORT_NEG_MIN) || (diff <= SHORT_POS_MAX);
        need     = {1'b0, cur_payload}
                 + {{PayloadWidth{1'b0}}, (cur_bit_pos == BIT_FIRST)}
                 + (is_short ? 10'd1 : 10'd2);

        base_valid_next = cur_base_valid;
        base_value_next = cur_base_value;
        payload_next    = cur_payload;
        bit_pos_next    = cur_bit_pos;
        byte_idx_next   = cur_byte_idx;
        full_next       = cur_full;

        out_data_next              = '0;
        out_data_next.code         = diff;
        out_data_next.bitmap_index = cur_byte_idx;
        out_data_next.bitmap_bit   = cur_bit_pos;

        if (!cur_base_valid)
        begin
            base_valid_next            = 1'b1;
            base_value_next            = s1_data_reg.sample;
            out_data_next.status       = STATUS_BASE;
            out_data_next.code         = '0;
            out_data_next.bitmap_index = '0;
            out_data_next.bitmap_bit   = '0;
        end
        else if (cur_full || (need > {2'b00, limit_reg}))
        begin
            full_next            = 1'b1;
            out_data_next.status = STATUS_REJECT;
        end
        else
        begin
            payload_next         = need[PayloadWidth-1:0];
            out_data_next.status = is_short ? STATUS_SHORT : STATUS_LONG;
            if (cur_bit_pos == BIT_LAST)
            begin
                bit_pos_next  = BIT_FIRST;
                byte_idx_next = cur_byte_idx + IndexWidth'(1);
            end
            else
            begin
                bit_pos_next = cur_bit_pos - BitWidth'(1);
            end
        end

        out_data_next.payload_bytes = payload_next;
        out_data_next.near_full     = ({1'b0, payload_next} + NEAR_MARGIN) >= {2'b00, limit_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            limit_reg      <= LIMIT_RESET;
            base_valid_reg <= 1'b0;
            base_value_reg <= '0;
            payload_reg    <= '0;
            bit_pos_reg    <= BIT_FIRST;
            byte_idx_reg   <= '0;
            full_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
            if (!in_stall)
            begin
                s1_valid_reg <= in_valid;
            end
            if (out_open)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (s1_fire)
            begin
                base_valid_reg <= base_valid_next;
                base_value_reg <= base_value_next;
                payload_reg    <= payload_next;
                bit_pos_reg    <= bit_pos_next;
                byte_idx_reg   <= byte_idx_next;
                full_reg       <= full_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_data_reg <= in_data;
        end
        if (s1_fire)
        begin
            out_data_reg <= out_data_next;
        end
    end

    a_full_has_base: assert property (@(posedge clk) disable iff (!rst_n)
        full_reg |-> base_valid_reg)
        else $error("packet full without a base");

    a_payload_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        !payload_reg[PayloadWidth-1])
        else $error("payload count beyond any limit");

    a_new_packet_base: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_data_reg.new_packet)
            |=> (out_valid_reg && out_data_reg.status == STATUS_BASE))
        else $error("new packet did not take a base");

endmodule

@@ verif/bitmap_flagged_delta_packer_tb.sv @@
`timescale 1ns / 1ps

module bitmap_flagged_delta_packer_tb;

    import bfdp_pkg::*;

    localparam int WatchdogLimit = 2000;
    localparam int HoldCycles    = 300;
    localparam int SegmentItems  = 120;
    localparam int Segments      = 12;
    localparam int PrintLimit    = 100;

    class packet_ledger;
        logic [LimitWidth-1:0]   limit;
        logic                    base_valid;
        logic [SampleWidth-1:0]  base_value;
        logic [PayloadWidth-1:0] payload;
        logic [BitWidth-1:0]     bit_pos;
        logic [IndexWidth-1:0]   byte_idx;
        logic                    full;
        out_t                    owed_results[$];
        int                      fail_count;

        function new();
            limit = LIMIT_RESET;
            fail_count = 0;
            clear_packet();
        endfunction

        function void clear_packet();
            base_valid = 1'b0;
            base_value = '0;
            payload = '0;
            bit_pos = BIT_FIRST;
            byte_idx = '0;
            full = 1'b0;
        endfunction

        function void take_sample(in_t item);
            out_t res;
            logic [SampleWidth-1:0] diff;
            logic is_short;
            int need;
            if (item.new_packet)
            begin
                clear_packet();
            end
            res = '0;
            if (!base_valid)
            begin
                base_value = item.sample;
                base_valid = 1'b1;
                res.status = STATUS_BASE;
            end
            else
            begin
                diff = item.sample - base_value;
                is_short = (diff >= SHORT_NEG_MIN) || (diff <= SHORT_POS_MAX);
                need = int'(payload) + ((bit_pos == BIT_FIRST) ? 1 : 0) + (is_short ? 1 : 2);
                res.code = diff;
                res.bitmap_index = byte_idx;
                res.bitmap_bit = bit_pos;
                if (full || need > int'(limit))
                begin
                    full = 1'b1;
                    res.status = STATUS_REJECT;
                end
                else
                begin
                    payload = need[PayloadWidth-1:0];
                    res.status = is_short ? STATUS_SHORT : STATUS_LONG;
                    if (bit_pos == BIT_LAST)
                    begin
                        bit_pos = BIT_FIRST;
                        byte_idx = byte_idx + IndexWidth'(1);
                    end
                    else
                    begin
                        bit_pos = bit_pos - BitWidth'(1);
                    end
                end
            end
            res.payload_bytes = payload;
            res.near_full = (int'(payload) + int'(NEAR_MARGIN) >= int'(limit));
            owed_results.push_back(res);
        endfunction

        task report(string what, int got_v, int exp_v);
            if (fail_count < PrintLimit)
            begin
                $display("mismatch %s: got %0d expected %0d at %0t", what, got_v, exp_v, $time);
            end
            fail_count++;
        endtask

        task check_result(out_t got);
            out_t exp_r;
            if (owed_results.size() == 0)
            begin
                report("unexpected result transaction, status", got.status, -1);
            end
            else
            begin
                exp_r = owed_results.pop_front();
                if (got.status !== exp_r.status)
                    report("status", got.status, exp_r.status);
                if (got.code !== exp_r.code)
                    report("code", got.code, exp_r.code);
                if (got.bitmap_index !== exp_r.bitmap_index)
                    report("bitmap_index", got.bitmap_index, exp_r.bitmap_index);
                if (got.bitmap_bit !== exp_r.bitmap_bit)
                    report("bitmap_bit", got.bitmap_bit, exp_r.bitmap_bit);
                if (got.payload_bytes !== exp_r.payload_bytes)
                    report("payload_bytes", got.payload_bytes, exp_r.payload_bytes);
                if (got.near_full !== exp_r.near_full)
                    report("near_full", got.near_full, exp_r.near_full);
            end
        endtask
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    in_t        in_data;
    logic       out_valid;
    logic       out_stall;
    out_t       out_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_data;

    packet_ledger ledger = new();

    int idle_pct;
    int stall_pct;
    int hold_requests;
    int hold_seen;
    int hold_left;
    int quiet_cycles;

    bitmap_flagged_delta_packer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        logic moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                ledger.limit = cfg_data;
                moved = 1'b1;
            end
            if (in_valid && !in_stall)
            begin
                ledger.take_sample(in_data);
                moved = 1'b1;
            end
            if (out_valid && !out_stall)
            begin
                ledger.check_result(out_data);
                moved = 1'b1;
            end
        end
        quiet_cycles <= moved ? 0 : quiet_cycles + 1;
    end

    // hold off the result side on request, else stall at random
    always @(negedge clk)
    begin
        if (hold_requests != hold_seen)
        begin
            hold_seen = hold_requests;
            hold_left = HoldCycles;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    initial
    begin
        while (quiet_cycles < WatchdogLimit)
            @(posedge clk);
        $display("FAIL bitmap_flagged_delta_packer");
        $finish;
    end

    function automatic in_t make_item(logic np, logic [SampleWidth-1:0] value);
        in_t item;
        item.new_packet = np;
        item.sample = value;
        return item;
    endfunction

    function automatic logic [SampleWidth-1:0] pick_delta();
        int d;
        case ($urandom_range(9)) inside
            [0:5]: d = int'($urandom_range(254)) - 128;
            6:
            begin
                case ($urandom_range(7))
                    0: d = 126;
                    1: d = 127;
                    2: d = -128;
                    3: d = -129;
                    4: d = 0;
                    5: d = -1;
                    6: d = 32767;
                    default: d = -32768;
                endcase
            end
            default: d = int'($urandom);
        endcase
        return d[SampleWidth-1:0];
    endfunction

    task automatic send_sample(input in_t item);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (ledger.owed_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_limit(input logic [7:0] value);
        in_valid <= 1'b0;
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [7:0] limits[Segments];
        logic [7:0] lim;
        logic [SampleWidth-1:0] base;
        int run_left;
        int first;
        in_t item;

        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        idle_pct = 0;
        stall_pct = 0;
        hold_requests = 0;
        hold_seen = 0;
        hold_left = 0;
        quiet_cycles = 0;
        limits = '{8'd255, 8'd4, 8'd64, 8'd0, 8'd200, 8'd0, 8'd3, 8'd255,
                   8'd1, 8'd0, 8'd16, 8'd255};
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // range edges and the second bitmap byte at the reset limit
        send_sample(make_item(1'b1, 16'h0000));
        send_sample(make_item(1'b0, 16'h0000));
        send_sample(make_item(1'b0, 16'h007E));
        send_sample(make_item(1'b0, 16'h007F));
        send_sample(make_item(1'b0, 16'hFF80));
        send_sample(make_item(1'b0, 16'hFF7F));
        send_sample(make_item(1'b0, 16'hFFFF));
        send_sample(make_item(1'b0, 16'h8000));
        send_sample(make_item(1'b0, 16'h7FFF));
        send_sample(make_item(1'b0, 16'h0001));
        send_sample(make_item(1'b1, 16'hFFFF));
        send_sample(make_item(1'b0, 16'h007D));
        send_sample(make_item(1'b0, 16'h007E));
        send_sample(make_item(1'b0, 16'hFF7F));

        // fill a tiny packet, stay rejected, then recover
        write_limit(8'd4);
        send_sample(make_item(1'b1, 16'h1234));
        send_sample(make_item(1'b0, 16'h1236));
        send_sample(make_item(1'b0, 16'h161C));
        send_sample(make_item(1'b0, 16'h1235));
        send_sample(make_item(1'b0, 16'h1234));
        send_sample(make_item(1'b1, 16'hABCD));
        send_sample(make_item(1'b0, 16'hADCD));
        send_sample(make_item(1'b0, 16'hAECD));

        write_limit(8'd0);
        send_sample(make_item(1'b1, 16'h0000));
        send_sample(make_item(1'b0, 16'h0005));

        run_left = 0;
        base = '0;
        for (int seg = 0; seg < Segments; seg++)
        begin
            lim = limits[seg];
            if (seg == 5 || seg == 9)
                lim = 8'($urandom_range(4, 255));
            write_limit(lim);
            case (seg % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 71; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 71; end
                default: begin idle_pct = 6; stall_pct = 6; end
            endcase
            for (int n = 0; n < SegmentItems; n++)
            begin
                if (seg == 4 && n == 40)
                    hold_requests++;
                first = 0;
                if (run_left == 0)
                begin
                    run_left = ($urandom_range(9) == 0) ? $urandom_range(100, 300)
                                                        : $urandom_range(1, 40);
                    base = 16'($urandom);
                    first = 1;
                end
                if ($urandom_range(19) == 0)
                begin
                    item.new_packet = 1'($urandom);
                    item.sample = 16'($urandom);
                end
                else if (first != 0)
                begin
                    item.new_packet = ($urandom_range(9) != 0);
                    item.sample = base;
                end
                else
                begin
                    item.new_packet = ($urandom_range(99) == 0);
                    item.sample = base + pick_delta();
                end
                send_sample(item);
                run_left--;
            end
        end

        in_valid <= 1'b0;
        wait_drained();
        if (ledger.fail_count == 0)
        begin
            $display("PASS bitmap_flagged_delta_packer");
        end
        else
        begin
            $display("FAIL bitmap_flagged_delta_packer");
        end
        $finish;
    end

endmodule
